### hdl/lsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpness measure: shared package
// Widths, constants, command and status words, and the dimension clamp.
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W      = 13;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PROD_W     = COL_W + ROW_W;

    localparam int SUM_W      = 44;
    localparam int COUNT_W    = 24;
    localparam int MEAN_W     = 28;
    localparam int Q_FRAC     = 8;
    localparam int DVD_W      = SUM_W + Q_FRAC;
    localparam int DIV_CNT_W  = $clog2(DVD_W);

    localparam int COEF_W     = 15;
    localparam int GRAY_SUM_W = 23;
    localparam int GRAY_SHIFT = 15;
    localparam logic [COEF_W-1:0] COEF_R = 15'd9798;
    localparam logic [COEF_W-1:0] COEF_G = 15'd19235;
    localparam logic [COEF_W-1:0] COEF_B = 15'd3736;

    localparam int LAP_W      = 12;
    localparam int MAG_W      = 10;
    localparam int SQ_W       = 2 * MAG_W;

    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic capture;
        logic shift;
        logic square;
        logic accumulate;
        logic load_div;
        logic div_step;
        logic out_load;
        logic cfg_write;
    } lsm_cmd_t;

    typedef struct packed {
        logic last_pixel;
        logic frame_ok;
    } lsm_stat_t;

    // Zero reads as one, anything above the maximum saturates.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/laplacian_sharpness_measure.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpness measure
// Streams RGB pixels of a frame and reports the summed squared 4-neighbour
// Laplacian of the gray image, the interior pixel count and the Q8 mean.
// Input: red/green/blue with in_valid; a word is taken at an edge where
// in_valid is high and in_stall is low, pixels in raster order. A pixel goes
// through accept with line store read, window shift, square and accumulate:
// the controller gives each stage its own state and stalls until the pixel
// is summed. On a frame's last pixel a restoring divider computes the mean
// and the result word is loaded into the output register; a frame too
// narrow or short skips the divider.
// Output: one word per frame, held in an output register until taken at an
// edge with out_valid high and out_stall low; the next frame's pixels are
// accepted meanwhile, and only a second finished result waits.
// Configuration: cfg_index 0 is frame width, 1 is frame height; a write
// restarts the frame and is taken only while no pixel is in flight.
// Reset sets 640 x 480 and clears positions, window and accumulator; the
// line store needs no clearing.
// ----------------------------------------------------------------------------
module laplacian_sharpness_measure (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     red,
    input  wire logic [7:0]                     green,
    input  wire logic [7:0]                     blue,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [lsm_pkg::SUM_W-1:0]           energy_sum,
    output logic [lsm_pkg::COUNT_W-1:0]         interior_count,
    output logic [lsm_pkg::MEAN_W-1:0]          mean_energy_q8,
    output logic                                frame_valid,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsm_pkg::DIM_W-1:0]      cfg_data
);
    import lsm_pkg::*;

    lsm_cmd_t  cmd;
    lsm_stat_t stat;

    lsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lsm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .energy_sum     (energy_sum),
        .interior_count (interior_count),
        .mean_energy_q8 (mean_energy_q8),
        .frame_valid    (frame_valid)
    );

endmodule
`default_nettype wire

### hdl/lsm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpness measure: datapath
// Gray conversion, line store, 3x3 window, squared Laplacian, accumulator,
// restoring divider for the Q8 mean, and the result registers.
// ----------------------------------------------------------------------------
module lsm_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lsm_pkg::lsm_cmd_t              cmd,
    output lsm_pkg::lsm_stat_t                  stat,
    input  wire logic [7:0]                     red,
    input  wire logic [7:0]                     green,
    input  wire logic [7:0]                     blue,
    input  wire logic [lsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsm_pkg::DIM_W-1:0]      cfg_data,
    output logic [lsm_pkg::SUM_W-1:0]           energy_sum,
    output logic [lsm_pkg::COUNT_W-1:0]         interior_count,
    output logic [lsm_pkg::MEAN_W-1:0]          mean_energy_q8,
    output logic                                frame_valid
);
    import lsm_pkg::*;

    logic [DIM_W-1:0]      width_reg, height_reg;
    logic [DIM_W-1:0]      w_eff, h_eff, w_m2, h_m2;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [PIX_W-1:0]      red_reg, green_reg, blue_reg;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [PIX_W-1:0]      gray;
    logic [2*PIX_W-1:0]    line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]    rd_data_reg;
    logic [PIX_W-1:0]      win_reg [3][3];
    logic signed [LAP_W-1:0] lap;
    logic [MAG_W-1:0]      lap_mag;
    logic [SQ_W-1:0]       sq_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic [SUM_W:0]        acc_sum;
    logic [SUM_W-1:0]      acc_next;
    logic                  interior;
    logic                  last_col, last_row;
    logic [SUM_W-1:0]      sum_hold_reg;
    logic [PROD_W-1:0]     count_reg;
    logic                  ok_reg;
    logic [DVD_W-1:0]      dvd_reg;
    logic [PROD_W-1:0]     rem_reg;
    logic [PROD_W:0]       trial;
    logic                  trial_ge;

    assign w_eff = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign h_eff = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));
    assign w_m2  = w_eff - DIM_W'(2);
    assign h_m2  = h_eff - DIM_W'(2);

    assign last_col = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
    assign last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= h_eff;
    assign interior = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2));

    assign stat.last_pixel = last_col && last_row;
    assign stat.frame_ok   = (w_eff >= DIM_W'(3)) && (h_eff >= DIM_W'(3));

    assign gray_sum = GRAY_SUM_W'(red_reg) * GRAY_SUM_W'(COEF_R)
                    + GRAY_SUM_W'(green_reg) * GRAY_SUM_W'(COEF_G)
                    + GRAY_SUM_W'(blue_reg) * GRAY_SUM_W'(COEF_B);
    assign gray = gray_sum[GRAY_SHIFT +: PIX_W];

    // Centre sits one column back in the middle row of the window.
    always_comb
    begin
        lap = LAP_W'(win_reg[0][1]) + LAP_W'(win_reg[2][1])
            + LAP_W'(win_reg[1][0]) + LAP_W'(win_reg[1][2])
            - (LAP_W'(win_reg[1][1]) << 2);
        lap_mag = lap[LAP_W-1] ? MAG_W'(-lap) : MAG_W'(lap);
    end

    always_comb
    begin
        acc_sum  = {1'b0, acc_reg} + (SUM_W + 1)'(sq_reg);
        acc_next = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
    end

    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge = trial >= {1'b0, count_reg};

    // Each word holds the older row in the upper byte and the newer row below.
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
            line_mem[col_reg] <= {rd_data_reg[PIX_W-1:0], gray};
        rd_data_reg <= line_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
        if (cmd.square)
            sq_reg <= lap_mag * lap_mag;
        if (cmd.load_div)
        begin
            sum_hold_reg <= acc_reg;
            count_reg    <= COL_W'(w_m2) * ROW_W'(h_m2);
            ok_reg       <= stat.frame_ok;
            dvd_reg      <= {acc_reg, {Q_FRAC{1'b0}}};
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? PROD_W'(trial - {1'b0, count_reg}) : PROD_W'(trial);
            dvd_reg <= {dvd_reg[DVD_W-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            energy_sum  <= ok_reg ? sum_hold_reg : '0;
            frame_valid <= ok_reg;
            if (!ok_reg)
                interior_count <= '0;
            else if (count_reg > PROD_W'({COUNT_W{1'b1}}))
                interior_count <= {COUNT_W{1'b1}};
            else
                interior_count <= COUNT_W'(count_reg);
            if (!ok_reg)
                mean_energy_q8 <= '0;
            else if (dvd_reg > DVD_W'({MEAN_W{1'b1}}))
                mean_energy_q8 <= {MEAN_W{1'b1}};
            else
                mean_energy_q8 <= MEAN_W'(dvd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            acc_reg    <= '0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
                col_reg <= '0;
                row_reg <= '0;
                acc_reg <= '0;
            end
            else if (cmd.load_div)
            begin
                acc_reg <= '0;
            end
            else if (cmd.accumulate)
            begin
                if (interior)
                    acc_reg <= acc_next;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (cmd.shift)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= rd_data_reg[2*PIX_W-1:PIX_W];
                win_reg[1][2] <= rd_data_reg[PIX_W-1:0];
                win_reg[2][2] <= gray;
            end
        end
    end

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(col_reg) < w_eff)
        else $error("column position outside the frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(row_reg) < h_eff)
        else $error("row position outside the frame height");

endmodule
`default_nettype wire

### hdl/lsm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Laplacian sharpness measure: controller
// Sequences each pixel through read, window, square and accumulate, then at
// frame end runs the divider, unless the frame is too narrow or short, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lsm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire lsm_pkg::lsm_stat_t  stat,
    output lsm_pkg::lsm_cmd_t        cmd
);
    import lsm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LAP  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        div_cnt_next  = div_cnt_reg;
        cmd           = '0;
        cmd.cfg_write = cfg_valid && cfg_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.shift  = 1'b1;
                state_next = S_LAP;
            end
            S_LAP:
            begin
                cmd.square = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = stat.last_pixel ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                cmd.load_div = 1'b1;
                div_cnt_next = '0;
                state_next   = stat.frame_ok ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DVD_W - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // Wait until the output register is free or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_READ)
        else $error("accepted pixel did not start the read step");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register loaded while a stalled word waits");

    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_cnt_reg < DIV_CNT_W'(DVD_W))
        else $error("divider ran past its step count");

endmodule
`default_nettype wire
